[rtl/nmea_sentence_collector_defines.svh]
// Assertion macros used by the NMEA sentence collector top level.
`ifndef NMEA_SENTENCE_COLLECTOR_DEFINES_SVH
`define NMEA_SENTENCE_COLLECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nsc assertion failed");

`endif

[rtl/nsc_pkg.sv]
// Shared constants, types and helpers of the NMEA sentence collector.
`default_nettype none
package nsc_pkg;

    localparam int MAX_SENTENCE_LEN = 128;
    localparam int MAX_SEPARATORS   = 32;
    localparam int MIN_LEN          = 12;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_GGA   = 2'd1;
    localparam logic [1:0] STATUS_RMC   = 2'd2;
    localparam logic [1:0] STATUS_OTHER = 2'd3;

    localparam logic [7:0] GGA_NAME [5] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
    localparam logic [7:0] RMC_NAME [5] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] sentence_length;
        logic [5:0] separator_count;
    } t_result;

    // 'A'-'F' and 'a'-'f' give 10..15, anything else is byte minus '0' mod 256
    function automatic logic [7:0] hex_value(input logic [7:0] a);
        logic [7:0] v;
        if (a >= 8'h41 && a <= 8'h46) begin
            v = a - 8'h37;
        end else if (a >= 8'h61 && a <= 8'h66) begin
            v = a - 8'h57;
        end else begin
            v = a - CH_ZERO;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/nsc_frame.sv]
// Sentence framing state machine with the registered per-word result.
`default_nettype none
module nsc_frame #(
    parameter int MAX_LEN  = nsc_pkg::MAX_SENTENCE_LEN,
    parameter int MAX_SEPS = nsc_pkg::MAX_SEPARATORS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output nsc_pkg::t_result      o_result
);
    import nsc_pkg::*;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_DATA  = 3'd1,
        PH_CK1   = 3'd2,
        PH_CK2   = 3'd3,
        PH_CR    = 3'd4,
        PH_LF    = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] byte_count;
        logic [5:0] sep_count;
        logic [7:0] running_xor;
        logic [7:0] hex_high;
        logic       letters_ok;
        logic       comma_ok;
        logic       gga_match;
        logic       rmc_match;
    } t_frame;

    localparam t_frame FRAME_CLEAR = '{
        phase:       PH_START,
        byte_count:  8'd0,
        sep_count:   6'd0,
        running_xor: 8'd0,
        hex_high:    8'd0,
        letters_ok:  1'b1,
        comma_ok:    1'b0,
        gga_match:   1'b1,
        rmc_match:   1'b1
    };

    localparam logic [7:0] LEN_LIMIT  = 8'(MAX_LEN);
    localparam logic [7:0] DATA_LIMIT = 8'(MAX_LEN - 4);
    localparam logic [5:0] SEP_LIMIT  = 6'(MAX_SEPS);
    localparam logic [7:0] LEN_MIN    = 8'(MIN_LEN);

    t_frame     r_st;
    t_frame     n_st;
    t_frame     cur;
    t_result    r_res;
    t_result    n_res;
    logic [7:0] inc_count;
    logic [2:0] name_idx;
    logic [7:0] want;

    always_comb begin
        cur = r_st;
        if (r_st.byte_count >= LEN_LIMIT || r_st.sep_count >= SEP_LIMIT) begin
            cur = FRAME_CLEAR;
        end
        inc_count = cur.byte_count + 8'd1;
        name_idx  = cur.byte_count[2:0] - 3'd1;
        want      = {cur.hex_high[3:0], 4'd0} | hex_value(i_byte);
        n_st      = cur;
        n_res     = '{status: STATUS_NONE, sentence_length: 8'd0, separator_count: 6'd0};

        unique case (cur.phase)
            PH_DATA: begin
                if (cur.byte_count >= 8'd1 && cur.byte_count <= 8'd5) begin
                    if (i_byte < 8'h41 || i_byte > 8'h5A) begin
                        n_st.letters_ok = 1'b0;
                    end
                    if (i_byte != GGA_NAME[name_idx]) begin
                        n_st.gga_match = 1'b0;
                    end
                    if (i_byte != RMC_NAME[name_idx]) begin
                        n_st.rmc_match = 1'b0;
                    end
                end else if (cur.byte_count == 8'd6) begin
                    n_st.comma_ok = (i_byte == CH_COMMA);
                end
                if (i_byte == CH_COMMA || i_byte == CH_STAR) begin
                    n_st.sep_count = cur.sep_count + 6'd1;
                end
                if (i_byte != CH_STAR) begin
                    n_st.running_xor = cur.running_xor ^ i_byte;
                end
                n_st.byte_count = inc_count;
                if (inc_count >= DATA_LIMIT) begin
                    n_st = FRAME_CLEAR;
                end
                if (i_byte == CH_STAR) begin
                    n_st.phase = PH_CK1;
                end
            end
            PH_CK1: begin
                n_st.hex_high   = hex_value(i_byte);
                n_st.byte_count = inc_count;
                n_st.phase      = PH_CK2;
            end
            PH_CK2: begin
                n_st.running_xor = cur.running_xor ^ want;
                n_st.byte_count  = inc_count;
                n_st.phase       = PH_CR;
            end
            PH_CR: begin
                if (i_byte == CH_CR) begin
                    n_st.byte_count = inc_count;
                    n_st.phase      = PH_LF;
                end else begin
                    n_st = FRAME_CLEAR;
                end
            end
            PH_LF: begin
                if (i_byte == CH_LF && inc_count >= LEN_MIN && cur.letters_ok &&
                    cur.comma_ok && cur.running_xor == 8'd0) begin
                    n_st.byte_count = inc_count;
                    n_st.phase      = PH_START;
                    n_res.status    = cur.gga_match ? STATUS_GGA :
                                      (cur.rmc_match ? STATUS_RMC : STATUS_OTHER);
                    n_res.sentence_length = inc_count;
                    n_res.separator_count = cur.sep_count;
                end else begin
                    n_st = FRAME_CLEAR;
                end
            end
            PH_START: begin
                if (i_byte == CH_DOLLAR) begin
                    n_st            = FRAME_CLEAR;
                    n_st.byte_count = 8'd1;
                    n_st.phase      = PH_DATA;
                end
            end
            default: begin
                n_st = FRAME_CLEAR;
                if (i_byte == CH_DOLLAR) begin
                    n_st.byte_count = 8'd1;
                    n_st.phase      = PH_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FRAME_CLEAR;
        end else if (i_step) begin
            r_st  <= n_st;
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

[rtl/nmea_sentence_collector.sv]
// Top level of the NMEA sentence collector: handshake, input and result stages.
//
// Input channel: i_valid / o_ready carry one received character per word on
// i_rx_byte. Output channel: o_valid / i_ready carry one status word per input
// word: o_status, o_sentence_length and o_separator_count. The status is
// nonzero only on the word that answers the LF closing a valid sentence.
// A word accepted into the input stage is passed to the framer when the result
// stage can take it; its result is then registered and presented on the ports.
// Throughput: one word per cycle while the receiver does not stall; the framing
// state, the running XOR and the counters are updated once per word by the
// framer logic that sits between the input stage and the result stage.
// Reset (i_rst_n low, synchronous) empties both stages and returns the framer
// to waiting for '$' with cleared counters.
// When the receiver stalls, the result holds on the ports, an empty input stage
// still takes one more word, and then o_ready drops until i_ready returns.
`default_nettype none
`include "nmea_sentence_collector_defines.svh"
module nmea_sentence_collector #(
    parameter int MAX_LEN  = nsc_pkg::MAX_SENTENCE_LEN,
    parameter int MAX_SEPS = nsc_pkg::MAX_SEPARATORS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_sentence_length,
    output logic [5:0]      o_separator_count
);
    import nsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;
    t_result    result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsc_frame #(
        .MAX_LEN  (MAX_LEN),
        .MAX_SEPS (MAX_SEPS)
    ) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    assign o_valid           = r_out_valid;
    assign o_status          = result.status;
    assign o_sentence_length = result.sentence_length;
    assign o_separator_count = result.separator_count;

    `NSC_ASSERT_NOW(a_empty_status, i_clk, i_rst_n, o_valid && o_status == STATUS_NONE, o_sentence_length == 8'd0 && o_separator_count == 6'd0)
    `NSC_ASSERT_NOW(a_min_length, i_clk, i_rst_n, o_valid && o_status != STATUS_NONE, o_sentence_length >= 8'(MIN_LEN))
    `NSC_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && o_ready, r_in_valid)
    `NSC_ASSERT_NEXT(a_step_delivers, i_clk, i_rst_n, advance, o_valid)

endmodule
`default_nettype wire
